### hdl/obstacle_avoid_drive_controller_macros.svh
`ifndef OBSTACLE_AVOID_DRIVE_CONTROLLER_MACROS_SVH
`define OBSTACLE_AVOID_DRIVE_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OADC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("oadc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OADC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("oadc: next-cycle check failed");

`endif

### hdl/oadc_pkg.sv
`default_nettype none

package oadc_pkg;

	localparam int TimeW   = 32;
	localparam int DistW   = 16;
	localparam int CmdW    = 8;
	localparam int SpeedW  = 10;
	localparam int CountW  = 16;
	localparam int HoldW   = 16;
	localparam int SecsW   = 23;
	localparam int CfgW    = 16;
	localparam int CfgIdxW = 3;
	localparam int NumDirs = 4;
	localparam int RecipW  = 29;

	typedef enum logic [2:0] {
		MOVE_STOP  = 3'd0,
		MOVE_FWD   = 3'd1,
		MOVE_BACK  = 3'd2,
		MOVE_LEFT  = 3'd3,
		MOVE_RIGHT = 3'd4
	} dir_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_NEAR_LIMIT     = 3'd0,
		REG_TURN_LIMIT     = 3'd1,
		REG_BACK_HOLD_MS   = 3'd2,
		REG_CORNER_HOLD_MS = 3'd3,
		REG_SIDE_HOLD_MS   = 3'd4,
		REG_CRUISE_SPEED   = 3'd5,
		REG_BACK_SPEED     = 3'd6,
		REG_CORNER_SPEED   = 3'd7
	} reg_idx_t;

	localparam logic [DistW-1:0]  NEAR_LIMIT_RST     = 16'd11;
	localparam logic [DistW-1:0]  TURN_LIMIT_RST     = 16'd18;
	localparam logic [HoldW-1:0]  BACK_HOLD_RST      = 16'd280;
	localparam logic [HoldW-1:0]  CORNER_HOLD_RST    = 16'd140;
	localparam logic [HoldW-1:0]  SIDE_HOLD_RST      = 16'd100;
	localparam logic [SpeedW-1:0] CRUISE_SPEED_RST   = 10'd300;
	localparam logic [SpeedW-1:0] BACK_SPEED_RST     = 10'd400;
	localparam logic [SpeedW-1:0] CORNER_SPEED_RST   = 10'd440;
	localparam logic [SpeedW-1:0] SIDE_SPEED         = 10'd380;

	localparam logic [CmdW-1:0] CMD_F_UP = 8'h46;
	localparam logic [CmdW-1:0] CMD_F_LO = 8'h66;
	localparam logic [CmdW-1:0] CMD_B_UP = 8'h42;
	localparam logic [CmdW-1:0] CMD_B_LO = 8'h62;
	localparam logic [CmdW-1:0] CMD_L_UP = 8'h4C;
	localparam logic [CmdW-1:0] CMD_L_LO = 8'h6C;
	localparam logic [CmdW-1:0] CMD_R_UP = 8'h52;
	localparam logic [CmdW-1:0] CMD_R_LO = 8'h72;
	localparam logic [CmdW-1:0] CMD_S_UP = 8'h53;
	localparam logic [CmdW-1:0] CMD_S_LO = 8'h73;

	// floor(x / 1000) = (x * MS_RECIP) >> RecipShift for every 32-bit x.
	localparam logic [RecipW-1:0] MS_RECIP   = 29'h10624DD3;
	localparam int                RecipShift = 38;
	localparam logic [SecsW-1:0]  MAX_SECS   = 23'd4294967;

	typedef struct packed {
		dir_t                           dir;
		logic [SpeedW-1:0]              speed;
		logic                           auto_on;
		logic                           in_result;
		logic [NumDirs-1:0][CountW-1:0] counts;
		logic [TimeW-1:0]               elapsed;
	} snap_t;

endpackage

`default_nettype wire

### hdl/oadc_cmd_if.sv
`default_nettype none

interface oadc_cmd_if import oadc_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [TimeW-1:0] now_ms;
	logic             button_click;
	logic [CmdW-1:0]  command_byte;
	logic [DistW-1:0] dist_left;
	logic [DistW-1:0] dist_center;
	logic [DistW-1:0] dist_right;

	modport source (
		output valid, now_ms, button_click, command_byte, dist_left, dist_center, dist_right,
		input  ready
	);

	modport sink (
		input  valid, now_ms, button_click, command_byte, dist_left, dist_center, dist_right,
		output ready
	);

endinterface

`default_nettype wire

### hdl/oadc_res_if.sv
`default_nettype none

interface oadc_res_if import oadc_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [2:0]        drive_dir;
	logic [SpeedW-1:0] drive_speed;
	logic              auto_active;
	logic              result_view;
	logic [CountW-1:0] forward_total;
	logic [CountW-1:0] backward_total;
	logic [CountW-1:0] left_total;
	logic [CountW-1:0] right_total;
	logic [SecsW-1:0]  run_seconds;

	modport source (
		output valid, drive_dir, drive_speed, auto_active, result_view,
		       forward_total, backward_total, left_total, right_total, run_seconds,
		input  ready
	);

	modport sink (
		input  valid, drive_dir, drive_speed, auto_active, result_view,
		       forward_total, backward_total, left_total, right_total, run_seconds,
		output ready
	);

endinterface

`default_nettype wire

### hdl/oadc_core.sv
`default_nettype none
`include "obstacle_avoid_drive_controller_macros.svh"

module oadc_core import oadc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CfgIdxW-1:0]   cfg_idx,
	input  logic [CfgW-1:0]      cfg_data,
	oadc_cmd_if.sink             cmd_ch,
	input  logic                 s2_adv,
	output logic                 valid_s1,
	output snap_t                snap_s1
);

	typedef struct packed {
		dir_t                           dir;
		logic [SpeedW-1:0]              speed;
		logic                           started;
		logic [TimeW-1:0]               rstart;
		logic [NumDirs-1:0][CountW-1:0] counts;
	} mot_t;

	logic [DistW-1:0]  near_limit_q;
	logic [DistW-1:0]  turn_limit_q;
	logic [HoldW-1:0]  back_hold_q;
	logic [HoldW-1:0]  corner_hold_q;
	logic [HoldW-1:0]  side_hold_q;
	logic [SpeedW-1:0] cruise_speed_q;
	logic [SpeedW-1:0] back_speed_q;
	logic [SpeedW-1:0] corner_speed_q;

	logic             auto_on_q, auto_d;
	logic             in_result_q, res_d;
	mot_t             mot_q, mot_d;
	logic [TimeW-1:0] elapsed_q, el_d;
	logic [TimeW-1:0] hold_begin_q, hb_d;
	logic [HoldW-1:0] hold_len_q, hl_d;
	logic             accept;
	logic [TimeW-1:0] now;

	function automatic mot_t clear_stats(mot_t s);
		mot_t t;
		t         = s;
		t.counts  = '0;
		t.rstart  = '0;
		t.started = 1'b0;
		return t;
	endfunction

	function automatic mot_t set_dir(mot_t s, dir_t d, logic [SpeedW-1:0] spd,
			logic [TimeW-1:0] tnow);
		mot_t       t;
		logic [1:0] k;
		t = s;
		k = 2'd0;
		if (s.dir != d) begin
			t.dir   = d;
			t.speed = (d == MOVE_STOP) ? '0 : spd;
			if (d != MOVE_STOP) begin
				if (!s.started) begin
					t.rstart  = tnow;
					t.started = 1'b1;
				end
				case (d)
					MOVE_FWD:  k = 2'd0;
					MOVE_BACK: k = 2'd1;
					MOVE_LEFT: k = 2'd2;
					default:   k = 2'd3;
				endcase
				if (s.counts[k] != '1) begin
					t.counts[k] = s.counts[k] + 16'd1;
				end
			end
		end
		return t;
	endfunction

	assign now           = cmd_ch.now_ms;
	assign cmd_ch.ready  = !valid_s1 || s2_adv;
	assign accept        = cmd_ch.valid && cmd_ch.ready;

	always_comb begin
		auto_d = auto_on_q;
		res_d  = in_result_q;
		mot_d  = mot_q;
		el_d   = elapsed_q;
		hb_d   = hold_begin_q;
		hl_d   = hold_len_q;

		if (cmd_ch.button_click) begin
			if (!in_result_q) begin
				if (!auto_on_q) begin
					auto_d = 1'b1;
					mot_d  = clear_stats(mot_d);
					el_d   = '0;
					hb_d   = now;
					hl_d   = '0;
					mot_d  = set_dir(mot_d, MOVE_STOP, '0, now);
				end else begin
					auto_d = 1'b0;
					mot_d  = set_dir(mot_d, MOVE_STOP, '0, now);
					if (mot_q.started) begin
						el_d = now - mot_q.rstart;
					end
					res_d = 1'b1;
				end
			end else begin
				mot_d = clear_stats(mot_d);
				el_d  = '0;
				res_d = 1'b0;
			end
		end

		if (!auto_d) begin
			case (cmd_ch.command_byte)
				CMD_F_UP, CMD_F_LO: mot_d = set_dir(mot_d, MOVE_FWD, cruise_speed_q, now);
				CMD_B_UP, CMD_B_LO: mot_d = set_dir(mot_d, MOVE_BACK, cruise_speed_q, now);
				CMD_L_UP, CMD_L_LO: mot_d = set_dir(mot_d, MOVE_LEFT, cruise_speed_q, now);
				CMD_R_UP, CMD_R_LO: mot_d = set_dir(mot_d, MOVE_RIGHT, cruise_speed_q, now);
				CMD_S_UP, CMD_S_LO: mot_d = set_dir(mot_d, MOVE_STOP, '0, now);
				default: ;
			endcase
		end else if ((now - hb_d) >= {{(TimeW-HoldW){1'b0}}, hl_d}) begin
			if (cmd_ch.dist_center < near_limit_q) begin
				mot_d = set_dir(mot_d, MOVE_BACK, back_speed_q, now);
				hl_d  = back_hold_q;
			end else if (cmd_ch.dist_center < turn_limit_q) begin
				mot_d = set_dir(mot_d,
					(cmd_ch.dist_left >= cmd_ch.dist_right) ? MOVE_LEFT : MOVE_RIGHT,
					corner_speed_q, now);
				hl_d  = corner_hold_q;
			end else if (cmd_ch.dist_left < near_limit_q) begin
				mot_d = set_dir(mot_d, MOVE_RIGHT, SIDE_SPEED, now);
				hl_d  = side_hold_q;
			end else if (cmd_ch.dist_right < near_limit_q) begin
				mot_d = set_dir(mot_d, MOVE_LEFT, SIDE_SPEED, now);
				hl_d  = side_hold_q;
			end else begin
				mot_d = set_dir(mot_d, MOVE_FWD, cruise_speed_q, now);
				hl_d  = '0;
			end
			hb_d = now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_limit_q   <= NEAR_LIMIT_RST;
			turn_limit_q   <= TURN_LIMIT_RST;
			back_hold_q    <= BACK_HOLD_RST;
			corner_hold_q  <= CORNER_HOLD_RST;
			side_hold_q    <= SIDE_HOLD_RST;
			cruise_speed_q <= CRUISE_SPEED_RST;
			back_speed_q   <= BACK_SPEED_RST;
			corner_speed_q <= CORNER_SPEED_RST;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_idx))
				REG_NEAR_LIMIT:     near_limit_q   <= cfg_data;
				REG_TURN_LIMIT:     turn_limit_q   <= cfg_data;
				REG_BACK_HOLD_MS:   back_hold_q    <= cfg_data;
				REG_CORNER_HOLD_MS: corner_hold_q  <= cfg_data;
				REG_SIDE_HOLD_MS:   side_hold_q    <= cfg_data;
				REG_CRUISE_SPEED:   cruise_speed_q <= cfg_data[SpeedW-1:0];
				REG_BACK_SPEED:     back_speed_q   <= cfg_data[SpeedW-1:0];
				REG_CORNER_SPEED:   corner_speed_q <= cfg_data[SpeedW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_on_q    <= 1'b0;
			in_result_q  <= 1'b0;
			mot_q        <= '{dir: MOVE_STOP, default: '0};
			elapsed_q    <= '0;
			hold_begin_q <= '0;
			hold_len_q   <= '0;
		end else if (accept) begin
			auto_on_q    <= auto_d;
			in_result_q  <= res_d;
			mot_q        <= mot_d;
			elapsed_q    <= el_d;
			hold_begin_q <= hb_d;
			hold_len_q   <= hl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			snap_s1.dir       <= mot_d.dir;
			snap_s1.speed     <= mot_d.speed;
			snap_s1.auto_on   <= auto_d;
			snap_s1.in_result <= res_d;
			snap_s1.counts    <= mot_d.counts;
			snap_s1.elapsed   <= el_d;
		end
	end

	// A stopped car always carries speed zero.
	`OADC_ASSERT_IMP(a_stop_speed, clk, arst_n, mot_q.dir == MOVE_STOP, mot_q.speed == '0)
	// The result view is only ever reached with autonomous mode off.
	`OADC_ASSERT_IMP(a_view_manual, clk, arst_n, in_result_q, !auto_on_q)
	// A word held in the first stage is not overwritten while the output stalls.
	`OADC_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !s2_adv,
		valid_s1 && $stable(snap_s1))

endmodule

`default_nettype wire

### hdl/oadc_secs.sv
`default_nettype none
`include "obstacle_avoid_drive_controller_macros.svh"

module oadc_secs import oadc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s1,
	input  snap_t        snap_s1,
	output logic         s2_adv,
	oadc_res_if.source   res_ch
);

	logic [TimeW+RecipW-1:0] prod;
	logic [SecsW-1:0]        secs;
	logic                    valid_s2;
	snap_t                   snap_s2;
	logic [SecsW-1:0]        secs_s2;

	assign prod   = snap_s1.elapsed * MS_RECIP;
	assign secs   = prod[RecipShift +: SecsW];
	assign s2_adv = !valid_s2 || res_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && valid_s1) begin
			snap_s2 <= snap_s1;
			secs_s2 <= secs;
		end
	end

	assign res_ch.valid          = valid_s2;
	assign res_ch.drive_dir      = snap_s2.dir;
	assign res_ch.drive_speed    = snap_s2.speed;
	assign res_ch.auto_active    = snap_s2.auto_on;
	assign res_ch.result_view    = snap_s2.in_result;
	assign res_ch.forward_total  = snap_s2.counts[0];
	assign res_ch.backward_total = snap_s2.counts[1];
	assign res_ch.left_total     = snap_s2.counts[2];
	assign res_ch.right_total    = snap_s2.counts[3];
	assign res_ch.run_seconds    = secs_s2;

	// The two views never show together in a delivered word.
	`OADC_ASSERT_IMP(a_out_views, clk, arst_n, res_ch.valid,
		!(res_ch.result_view && res_ch.auto_active))
	// Seconds derived from a 32-bit millisecond span stay within range.
	`OADC_ASSERT_IMP(a_secs_range, clk, arst_n, res_ch.valid, res_ch.run_seconds <= MAX_SECS)

endmodule

`default_nettype wire

### hdl/obstacle_avoid_drive_controller.sv
// Channel   Dir  Handshake      Word
// cfg       in   cfg_wen only   cfg_idx, cfg_data (16 bits, speeds use the low 10)
// cmd_ch    in   valid/ready    time, button, command byte, three distances
// res_ch    out  valid/ready    direction, speed, mode flags, four totals, seconds
//
// From acceptance to result a control pass goes through the first stage, holding the
// state update and its snapshot, and the second, holding the divide-by-1000 multiply.
// One pass is accepted every cycle while the result channel keeps pace.
// When res_ch stalls, a pass is still taken into the first stage while it is empty.
// Reset brings the configuration to its defaults and the car to a stop in manual mode.
`default_nettype none

module obstacle_avoid_drive_controller import oadc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [CfgW-1:0]    cfg_data,
	oadc_cmd_if.sink           cmd_ch,
	oadc_res_if.source         res_ch
);

	logic  valid_s1;
	snap_t snap_s1;
	logic  s2_adv;

	oadc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd_ch   (cmd_ch),
		.s2_adv   (s2_adv),
		.valid_s1 (valid_s1),
		.snap_s1  (snap_s1)
	);

	oadc_secs u_secs (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.snap_s1  (snap_s1),
		.s2_adv   (s2_adv),
		.res_ch   (res_ch)
	);

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import oadc_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int TURN_ROUNDS = 5;
	localparam logic [CmdW-1:0] LETTERS [10] = '{
		CMD_F_UP, CMD_F_LO, CMD_B_UP, CMD_B_LO, CMD_L_UP,
		CMD_L_LO, CMD_R_UP, CMD_R_LO, CMD_S_UP, CMD_S_LO
	};

	typedef struct {
		logic [TimeW-1:0] now_ms;
		logic             click;
		logic [CmdW-1:0]  cmd;
		logic [DistW-1:0] dl;
		logic [DistW-1:0] dc;
		logic [DistW-1:0] dr;
	} pass_word_t;

	typedef struct {
		dir_t              dir;
		logic [SpeedW-1:0] speed;
		logic              auto_active;
		logic              result_view;
		logic [CountW-1:0] totals [NumDirs];
		logic [SecsW-1:0]  secs;
	} status_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wen;
	logic [CfgIdxW-1:0] cfg_idx;
	logic [CfgW-1:0]    cfg_data;

	oadc_cmd_if cmd_ch ();
	oadc_res_if res_ch ();

	obstacle_avoid_drive_controller uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd_ch   (cmd_ch),
		.res_ch   (res_ch)
	);

	pass_word_t pending [$];
	status_t    due_status [$];
	logic       cmd_taken = 1'b0;
	logic       failed = 1'b0;
	int         send_idle = 7;
	int         recv_idle = 86;
	int         cycle_count = 0;

	// Shadow of the controller: configuration and driving state.
	logic [DistW-1:0]  lim_near, lim_turn;
	logic [HoldW-1:0]  hold_back, hold_corner, hold_side;
	logic [SpeedW-1:0] spd_cruise, spd_back, spd_corner;
	logic              st_auto, st_review, st_started;
	dir_t              st_dir;
	logic [SpeedW-1:0] st_speed;
	logic [TimeW-1:0]  st_start, st_hold_t0;
	logic [SecsW-1:0]  st_secs;
	logic [CountW-1:0] st_counts [NumDirs];
	logic [HoldW-1:0]  st_hold_len;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic wipe_stats();
		for (int i = 0; i < NumDirs; i++)
			st_counts[i] = '0;
		st_start   = '0;
		st_started = 1'b0;
		st_secs    = '0;
	endtask

	task automatic steer(dir_t d, logic [SpeedW-1:0] spd, logic [TimeW-1:0] now);
		if (st_dir == d)
			return;
		st_dir   = d;
		st_speed = (d == MOVE_STOP) ? '0 : spd;
		if (d != MOVE_STOP && !st_started) begin
			st_start   = now;
			st_started = 1'b1;
		end
		if (d != MOVE_STOP && st_counts[int'(d) - 1] != 16'hFFFF)
			st_counts[int'(d) - 1] = st_counts[int'(d) - 1] + 1'b1;
	endtask

	task automatic drive_pass(pass_word_t w);
		status_t s;
		if (w.click) begin
			if (!st_review) begin
				if (!st_auto) begin
					st_auto = 1'b1;
					wipe_stats();
					st_hold_t0  = w.now_ms;
					st_hold_len = '0;
					steer(MOVE_STOP, '0, w.now_ms);
				end else begin
					st_auto = 1'b0;
					steer(MOVE_STOP, '0, w.now_ms);
					if (st_started)
						st_secs = SecsW'((w.now_ms - st_start) / 1000);
					st_review = 1'b1;
				end
			end else begin
				wipe_stats();
				st_review = 1'b0;
			end
		end
		if (!st_auto) begin
			case (w.cmd)
				CMD_F_UP, CMD_F_LO: steer(MOVE_FWD, spd_cruise, w.now_ms);
				CMD_B_UP, CMD_B_LO: steer(MOVE_BACK, spd_cruise, w.now_ms);
				CMD_L_UP, CMD_L_LO: steer(MOVE_LEFT, spd_cruise, w.now_ms);
				CMD_R_UP, CMD_R_LO: steer(MOVE_RIGHT, spd_cruise, w.now_ms);
				CMD_S_UP, CMD_S_LO: steer(MOVE_STOP, '0, w.now_ms);
				default: ;
			endcase
		end else if (w.now_ms - st_hold_t0 >= TimeW'(st_hold_len)) begin
			if (w.dc < lim_near) begin
				steer(MOVE_BACK, spd_back, w.now_ms);
				st_hold_len = hold_back;
			end else if (w.dc < lim_turn) begin
				if (w.dl >= w.dr)
					steer(MOVE_LEFT, spd_corner, w.now_ms);
				else
					steer(MOVE_RIGHT, spd_corner, w.now_ms);
				st_hold_len = hold_corner;
			end else if (w.dl < lim_near) begin
				steer(MOVE_RIGHT, SIDE_SPEED, w.now_ms);
				st_hold_len = hold_side;
			end else if (w.dr < lim_near) begin
				steer(MOVE_LEFT, SIDE_SPEED, w.now_ms);
				st_hold_len = hold_side;
			end else begin
				steer(MOVE_FWD, spd_cruise, w.now_ms);
				st_hold_len = '0;
			end
			st_hold_t0 = w.now_ms;
		end
		s.dir         = st_dir;
		s.speed       = st_speed;
		s.auto_active = st_auto;
		s.result_view = st_review;
		s.totals      = st_counts;
		s.secs        = st_secs;
		due_status.push_back(s);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	initial begin
		lim_near    = NEAR_LIMIT_RST;
		lim_turn    = TURN_LIMIT_RST;
		hold_back   = BACK_HOLD_RST;
		hold_corner = CORNER_HOLD_RST;
		hold_side   = SIDE_HOLD_RST;
		spd_cruise  = CRUISE_SPEED_RST;
		spd_back    = BACK_SPEED_RST;
		spd_corner  = CORNER_SPEED_RST;
		st_auto     = 1'b0;
		st_review   = 1'b0;
		st_dir      = MOVE_STOP;
		st_speed    = '0;
		st_hold_t0  = '0;
		st_hold_len = '0;
		wipe_stats();
	end

	// Accepted words feed the shadow model, results are checked against it.
	always @(posedge clk) begin
		status_t s;
		cmd_taken <= cmd_ch.valid && cmd_ch.ready;
		if (cfg_wen) begin
			case (reg_idx_t'(cfg_idx))
				REG_NEAR_LIMIT:     lim_near    = cfg_data;
				REG_TURN_LIMIT:     lim_turn    = cfg_data;
				REG_BACK_HOLD_MS:   hold_back   = cfg_data;
				REG_CORNER_HOLD_MS: hold_corner = cfg_data;
				REG_SIDE_HOLD_MS:   hold_side   = cfg_data;
				REG_CRUISE_SPEED:   spd_cruise  = cfg_data[SpeedW-1:0];
				REG_BACK_SPEED:     spd_back    = cfg_data[SpeedW-1:0];
				REG_CORNER_SPEED:   spd_corner  = cfg_data[SpeedW-1:0];
				default: ;
			endcase
		end
		if (cmd_ch.valid && cmd_ch.ready)
			drive_pass('{cmd_ch.now_ms, cmd_ch.button_click, cmd_ch.command_byte,
				cmd_ch.dist_left, cmd_ch.dist_center, cmd_ch.dist_right});
		if (res_ch.valid && res_ch.ready) begin
			if (due_status.size() == 0) begin
				$error("result word with nothing expected");
				failed = 1'b1;
			end else begin
				s = due_status.pop_front();
				check_field("drive_dir", 32'(s.dir), 32'(res_ch.drive_dir));
				check_field("drive_speed", 32'(s.speed), 32'(res_ch.drive_speed));
				check_field("auto_active", 32'(s.auto_active), 32'(res_ch.auto_active));
				check_field("result_view", 32'(s.result_view), 32'(res_ch.result_view));
				check_field("forward_total", 32'(s.totals[0]), 32'(res_ch.forward_total));
				check_field("backward_total", 32'(s.totals[1]), 32'(res_ch.backward_total));
				check_field("left_total", 32'(s.totals[2]), 32'(res_ch.left_total));
				check_field("right_total", 32'(s.totals[3]), 32'(res_ch.right_total));
				check_field("run_seconds", 32'(s.secs), 32'(res_ch.run_seconds));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(negedge clk) begin
		pass_word_t w;
		if (arst_n && (!cmd_ch.valid || cmd_taken)) begin
			if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
				w = pending.pop_front();
				cmd_ch.valid        <= 1'b1;
				cmd_ch.now_ms       <= w.now_ms;
				cmd_ch.button_click <= w.click;
				cmd_ch.command_byte <= w.cmd;
				cmd_ch.dist_left    <= w.dl;
				cmd_ch.dist_center  <= w.dc;
				cmd_ch.dist_right   <= w.dr;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		res_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle);

	function automatic pass_word_t mk(logic [TimeW-1:0] t, logic c, logic [CmdW-1:0] b,
			logic [DistW-1:0] l, logic [DistW-1:0] m, logic [DistW-1:0] r);
		mk = '{t, c, b, l, m, r};
	endfunction

	function automatic logic [DistW-1:0] pick_dist();
		if ($urandom_range(3) == 0)
			return DistW'($urandom_range(65535));
		return DistW'($urandom_range(40));
	endfunction

	task automatic wait_drained();
		do begin
			@(negedge clk);
			#1;
		end while (pending.size() != 0 || cmd_ch.valid || due_status.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_regs(logic [CfgW-1:0] vals [8]);
		for (int i = 0; i < 8; i++) begin
			@(negedge clk);
			cfg_wen  <= 1'b1;
			cfg_idx  <= CfgIdxW'(i);
			cfg_data <= vals[i];
		end
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		logic [CfgW-1:0]  vals [8];
		logic [TimeW-1:0] t;
		logic [CmdW-1:0]  b;
		const logic [DistW-1:0] FAR = 16'hFFFF;

		arst_n              = 1'b0;
		cfg_wen             = 1'b0;
		cfg_idx             = '0;
		cfg_data            = '0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.now_ms       = '0;
		cmd_ch.button_click = 1'b0;
		cmd_ch.command_byte = '0;
		cmd_ch.dist_left    = '0;
		cmd_ch.dist_center  = '0;
		cmd_ch.dist_right   = '0;
		res_ch.ready        = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Manual letters in both cases, ignored bytes, then an autonomous run.
		for (int i = 0; i < 10; i++)
			pending.push_back(mk(100 + 10 * i, 1'b0, LETTERS[(i * 3) % 10], FAR, FAR, FAR));
		pending.push_back(mk(200, 1'b0, 8'h00, 16'd0, 16'd0, 16'd0));
		pending.push_back(mk(210, 1'b0, 8'hFF, FAR, FAR, FAR));
		pending.push_back(mk(0, 1'b1, CMD_F_UP, FAR, FAR, FAR));
		pending.push_back(mk(50, 1'b0, CMD_S_UP, FAR, 16'd0, FAR));
		pending.push_back(mk(100, 1'b0, 8'h00, FAR, FAR, FAR));
		pending.push_back(mk(330, 1'b0, 8'h00, 16'd40, 16'd15, 16'd40));
		pending.push_back(mk(470, 1'b0, 8'h00, 16'd3, 16'd11, 16'd50));
		pending.push_back(mk(610, 1'b0, 8'h00, FAR, FAR, 16'd10));
		pending.push_back(mk(710, 1'b0, 8'h00, 16'd10, 16'd65534, FAR));
		pending.push_back(mk(810, 1'b0, 8'h00, FAR, FAR, FAR));
		pending.push_back(mk(32'hFFFF_FFFF, 1'b0, 8'h00, FAR, 16'd10, FAR));
		pending.push_back(mk(32'h0000_0010, 1'b0, 8'h00, FAR, FAR, FAR));
		pending.push_back(mk(32'h0000_0120, 1'b0, 8'h00, FAR, FAR, FAR));
		pending.push_back(mk(32'h0000_1000, 1'b1, CMD_L_LO, FAR, FAR, FAR));
		pending.push_back(mk(32'h0000_2000, 1'b1, 8'h00, FAR, FAR, FAR));
		wait_drained();

		t = $urandom();
		for (int seg = 0; seg < 6; seg++) begin
			send_idle = (seg < 2) ? 7 : (seg < 4) ? 86 : 0;
			recv_idle = (seg < 2) ? 86 : (seg < 4) ? 7 : 0;
			if (seg != 0) begin
				for (int i = 0; i < 8; i++)
					vals[i] = (seg == 1) ? 16'h0000 : (seg == 3) ? 16'hFFFF : 16'($urandom());
				if (seg != 1 && seg != 3) begin
					vals[REG_NEAR_LIMIT]     = 16'($urandom_range(5, 30));
					vals[REG_TURN_LIMIT]     = vals[REG_NEAR_LIMIT] + 16'($urandom_range(30));
					vals[REG_BACK_HOLD_MS]   = 16'($urandom_range(400));
					vals[REG_CORNER_HOLD_MS] = 16'($urandom_range(400));
					vals[REG_SIDE_HOLD_MS]   = 16'($urandom_range(400));
				end
				write_regs(vals);
			end
			for (int n = 0; n < 130; n++) begin
				if ($urandom_range(49) == 0)
					t = $urandom();
				else
					t = t + $urandom_range(150);
				if ($urandom_range(9) < 6)
					b = LETTERS[$urandom_range(9)];
				else
					b = CmdW'($urandom_range(255));
				pending.push_back(mk(t, $urandom_range(99) < 4, b,
					pick_dist(), pick_dist(), pick_dist()));
			end
			wait_drained();
		end

		// Back to manual driving view, then step through every direction a few times.
		if (st_auto) begin
			pending.push_back(mk(t, 1'b1, 8'h00, FAR, FAR, FAR));
			wait_drained();
		end
		if (st_review) begin
			pending.push_back(mk(t, 1'b1, 8'h00, FAR, FAR, FAR));
			wait_drained();
		end
		for (int n = 0; n < TURN_ROUNDS; n++) begin
			pending.push_back(mk(t + n, 1'b0, CMD_F_UP, FAR, FAR, FAR));
			pending.push_back(mk(t + n, 1'b0, CMD_B_LO, FAR, FAR, FAR));
			pending.push_back(mk(t + n, 1'b0, CMD_L_UP, FAR, FAR, FAR));
			pending.push_back(mk(t + n, 1'b0, CMD_R_LO, FAR, FAR, FAR));
		end
		wait_drained();
		repeat (10) @(posedge clk);

		if (!failed && due_status.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
